[rtl/core/spfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_pkg
// Shared types and constants of the sync packet framer with checksum.
// ----------------------------------------------------------------------------
package spfc_pkg;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned HDR_BYTES = 4;

	// Byte positions inside the header.
	localparam int unsigned POS_SYNC_FIRST  = 0;
	localparam int unsigned POS_SYNC_SECOND = 1;
	localparam int unsigned POS_COMMAND     = 2;
	localparam int unsigned POS_LENGTH      = 3;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAB;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h3C;
	localparam logic [BYTE_W-1:0] COMMAND_RST     = 8'h12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_COMMAND     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] command_byte;
	} hdr_cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  value_count;
		logic [SAMPLE_W-1:0] sample_value;
	} item_t;

endpackage

[rtl/core/sync_packet_framer_checksum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_packet_framer_checksum
// Frames packets of values into a byte stream with header and checksum.
// ----------------------------------------------------------------------------
// Input stream: one value per transaction. When no packet is open, the item's
// count starts one: two sync bytes, the command byte and a length byte go out,
// then the value bytes, least significant first. The byte after the last
// value is the checksum, the sum modulo 256 of all earlier packet bytes, and
// it carries tlast. A count of zero gives header and checksum only.
// Output stream: one byte per transaction.
// An item goes from the input register through the serializer's work state
// into the output register. The serializer's byte sequencer gives one byte
// per cycle while the receiver is ready: (VALUE_WIDTH + 7) / 8 per item (two
// at the default), four more if it opens a packet and one if it closes one.
// A stalled receiver holds the output register; one further item waits in the
// input register, and then tready drops. Reset empties both and restores the
// header registers to 0xAB, 0x3C and 0x12; header writes should happen only
// while the block is idle.
// ----------------------------------------------------------------------------
module sync_packet_framer_checksum #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [15:0] sample_value, [22:16] value_count, [23] zero
	input  logic [23:0]                     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] tx_byte
	output logic [7:0]                      m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [spfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_data
);

	spfc_pkg::hdr_cfg_t hdr_cfg_q;
	spfc_pkg::item_t    in_item;
	spfc_pkg::item_t    pend_item;
	logic               pend_valid;
	logic               load;

	assign in_item.sample_value = s_axis_tdata[15:0];
	assign in_item.value_count  = s_axis_tdata[22:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cfg_q.sync_first   <= spfc_pkg::SYNC_FIRST_RST;
			hdr_cfg_q.sync_second  <= spfc_pkg::SYNC_SECOND_RST;
			hdr_cfg_q.command_byte <= spfc_pkg::COMMAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				spfc_pkg::REG_SYNC_FIRST: begin
					hdr_cfg_q.sync_first <= cfg_data;
				end
				spfc_pkg::REG_SYNC_SECOND: begin
					hdr_cfg_q.sync_second <= cfg_data;
				end
				spfc_pkg::REG_COMMAND: begin
					hdr_cfg_q.command_byte <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	spfc_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.in_item       (in_item),
		.load          (load),
		.pend_valid    (pend_valid),
		.pend_item     (pend_item)
	);

	spfc_serializer #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_serializer (
		.clk           (clk),
		.arst_n        (arst_n),
		.hdr_cfg       (hdr_cfg_q),
		.pend_valid    (pend_valid),
		.pend_item     (pend_item),
		.load          (load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[rtl/core/spfc_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_in_reg
// Input holding register: takes one input transaction while the serializer
// is still busy with the previous item.
// ----------------------------------------------------------------------------
module spfc_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  spfc_pkg::item_t  in_item,
	input  logic             load,
	output logic             pend_valid,
	output spfc_pkg::item_t  pend_item
);

	logic            pend_valid_q;
	spfc_pkg::item_t pend_item_q;

	assign s_axis_tready = !pend_valid_q;
	assign pend_valid    = pend_valid_q;
	assign pend_item     = pend_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (s_axis_tvalid && !pend_valid_q) begin
			pend_valid_q <= 1'b1;
		end else if (load) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && !pend_valid_q) begin
			pend_item_q <= in_item;
		end
	end

	// A held item must not change or vanish before the serializer takes it.
	a_pend_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q && !load |=> pend_valid_q && $stable(pend_item_q))
		else $error("pending item lost or changed before load");

endmodule

[rtl/core/spfc_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_serializer
// Walks an item through header, value bytes and checksum as its packet needs,
// one byte per unstalled cycle, into the output register. Keeps packet state.
// ----------------------------------------------------------------------------
module spfc_serializer #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spfc_pkg::hdr_cfg_t            hdr_cfg,
	input  logic                          pend_valid,
	input  spfc_pkg::item_t               pend_item,
	output logic                          load,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [spfc_pkg::BYTE_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tlast
);

	localparam int unsigned BPV   = (VALUE_WIDTH + 7) / 8;
	localparam int unsigned VB    = BPV * 8;
	localparam int unsigned CW    = (VALUE_WIDTH < spfc_pkg::SAMPLE_W) ?
	                                VALUE_WIDTH : spfc_pkg::SAMPLE_W;
	localparam int unsigned IDX_W = $clog2(spfc_pkg::HDR_BYTES + BPV + 1);
	localparam logic [IDX_W-1:0] CHK_IDX = IDX_W'(spfc_pkg::HDR_BYTES + BPV);
	localparam logic [IDX_W-1:0] VAL_IDX = IDX_W'(spfc_pkg::HDR_BYTES);

	logic                                work_valid_q;
	logic [IDX_W-1:0]                    idx_q;
	logic                                has_value_q;
	logic                                has_end_q;
	logic [spfc_pkg::BYTE_W-1:0]         len_q;
	logic [BPV-1:0][7:0]                 val_q;
	logic [spfc_pkg::COUNT_W-1:0]        values_left_q;
	logic [spfc_pkg::BYTE_W-1:0]         sum_q;
	logic                                out_valid_q;
	logic [spfc_pkg::BYTE_W-1:0]         out_byte_q;
	logic                                out_last_q;

	logic                                advance;
	logic                                emit;
	logic                                finish;
	logic [IDX_W-1:0]                    last_idx;
	logic [IDX_W-1:0]                    idx_next;
	logic                                is_chk;
	logic [spfc_pkg::BYTE_W-1:0]         cur_byte;
	logic                                start_pkt;
	logic                                empty_pkt;
	logic [spfc_pkg::COUNT_W-1:0]        vl_next;
	logic [VB-1:0]                       val_ext;
	logic [9:0]                          len_full;

	assign advance  = !out_valid_q || m_axis_tready;
	assign emit     = work_valid_q && advance;
	assign last_idx = has_end_q ? CHK_IDX : CHK_IDX - IDX_W'(1);
	assign finish   = emit && (idx_q == last_idx);
	assign load     = pend_valid && (!work_valid_q || finish);
	assign is_chk   = (idx_q == CHK_IDX);

	// An item without values jumps from the length byte straight to the checksum.
	assign idx_next = (idx_q == IDX_W'(spfc_pkg::POS_LENGTH) && !has_value_q) ?
	                  CHK_IDX : idx_q + IDX_W'(1);

	always_comb begin
		cur_byte = sum_q;
		if (idx_q == IDX_W'(spfc_pkg::POS_SYNC_FIRST)) begin
			cur_byte = hdr_cfg.sync_first;
		end else if (idx_q == IDX_W'(spfc_pkg::POS_SYNC_SECOND)) begin
			cur_byte = hdr_cfg.sync_second;
		end else if (idx_q == IDX_W'(spfc_pkg::POS_COMMAND)) begin
			cur_byte = hdr_cfg.command_byte;
		end else if (idx_q == IDX_W'(spfc_pkg::POS_LENGTH)) begin
			cur_byte = len_q;
		end else begin
			for (int k = 0; k < BPV; k++) begin
				if (idx_q == VAL_IDX + IDX_W'(k)) begin
					cur_byte = val_q[k];
				end
			end
		end
	end

	// Load-time decode of the pending item against the packet state.
	assign start_pkt = (values_left_q == '0);
	assign empty_pkt = start_pkt && (pend_item.value_count == '0);
	assign vl_next   = start_pkt ?
	                   (empty_pkt ? '0 : pend_item.value_count - spfc_pkg::COUNT_W'(1)) :
	                   values_left_q - spfc_pkg::COUNT_W'(1);
	assign len_full  = 10'(pend_item.value_count) * 10'(BPV);

	always_comb begin
		val_ext = '0;
		for (int i = 0; i < CW; i++) begin
			val_ext[i] = pend_item.sample_value[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q  <= 1'b0;
			idx_q         <= '0;
			has_value_q   <= 1'b0;
			has_end_q     <= 1'b0;
			values_left_q <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				work_valid_q  <= 1'b1;
				idx_q         <= start_pkt ? '0 : VAL_IDX;
				has_value_q   <= !empty_pkt;
				has_end_q     <= (vl_next == '0);
				values_left_q <= vl_next;
			end else if (finish) begin
				work_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_next;
			end
			if (emit) begin
				if (is_chk) begin
					sum_q <= '0;
				end else if (idx_q == IDX_W'(spfc_pkg::POS_SYNC_FIRST)) begin
					sum_q <= cur_byte;
				end else begin
					sum_q <= sum_q + cur_byte;
				end
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			len_q <= len_full[7:0];
			val_q <= val_ext;
		end
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_chk;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		work_valid_q |-> idx_q <= last_idx)
		else $error("byte position ran past the end of the item");

	a_chk_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_chk |-> finish && values_left_q == '0)
		else $error("checksum byte sent in the middle of a packet");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_chk |=> sum_q == '0)
		else $error("running sum not cleared after checksum");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync packet framer with additive checksum.
// ----------------------------------------------------------------------------
// Packets of 16-bit values go in on the input stream. A small scoreboard class
// predicts every framed byte and compares each output transaction with the
// oldest expected byte. The predicted bytes are the two sync bytes, the command
// byte, the length byte, the value bytes (low byte first), and the checksum
// carrying tlast.
// A short directed part covers these cases:
//   - empty packets and extreme values,
//   - all-zero and all-one header registers,
//   - a write to the unused register index,
//   - a header write in the middle of a packet.
// A random part follows. It sends packets of mostly small sizes and one of
// the largest size, with header writes between packets. Both sides idle in
// short bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned VALUE_BYTES  = (spfc_pkg::SAMPLE_W + 7) / 8;
	localparam int unsigned RANDOM_ITEMS = 300;
	localparam int unsigned QUIET_AFTER  = 255;
	localparam int unsigned DRAIN_CYCLES = 8;
	// No register sits at this index, so a write there must change nothing.
	localparam logic [spfc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [spfc_pkg::BYTE_W-1:0] tx_byte;
		logic                        packet_end;
	} stream_byte_t;

	class packet_byte_predictor;
		stream_byte_t                 expected_bytes[$];
		logic [spfc_pkg::BYTE_W-1:0]  hdr_sync_first;
		logic [spfc_pkg::BYTE_W-1:0]  hdr_sync_second;
		logic [spfc_pkg::BYTE_W-1:0]  hdr_command;
		logic [spfc_pkg::COUNT_W-1:0] values_pending;
		logic [spfc_pkg::BYTE_W-1:0]  byte_sum;
		int unsigned                  mismatches;
		int unsigned                  bytes_checked;
		int unsigned                  packets_framed;
		int unsigned                  reg_writes;

		function new();
			hdr_sync_first  = spfc_pkg::SYNC_FIRST_RST;
			hdr_sync_second = spfc_pkg::SYNC_SECOND_RST;
			hdr_command     = spfc_pkg::COMMAND_RST;
			values_pending  = '0;
			byte_sum        = '0;
			mismatches      = 0;
			bytes_checked   = 0;
			packets_framed  = 0;
			reg_writes      = 0;
		endfunction

		function void write_reg(logic [spfc_pkg::CFG_IDX_W-1:0] index,
			logic [spfc_pkg::BYTE_W-1:0] value);
			reg_writes++;
			case (index)
				spfc_pkg::REG_SYNC_FIRST: begin
					hdr_sync_first = value;
				end
				spfc_pkg::REG_SYNC_SECOND: begin
					hdr_sync_second = value;
				end
				spfc_pkg::REG_COMMAND: begin
					hdr_command = value;
				end
				default: begin
				end
			endcase
		endfunction

		function void push_byte(logic [spfc_pkg::BYTE_W-1:0] value, logic is_end);
			stream_byte_t b;
			b.tx_byte    = value;
			b.packet_end = is_end;
			expected_bytes.push_back(b);
			if (!is_end)
				byte_sum = byte_sum + value;
		endfunction

		function void push_checksum();
			push_byte(byte_sum, 1'b1);
			byte_sum = '0;
			packets_framed++;
		endfunction

		// Called for every accepted input transaction.
		function void note_item(logic [spfc_pkg::SAMPLE_W-1:0] value_word,
			logic [spfc_pkg::COUNT_W-1:0] count);
			if (values_pending == 0) begin
				byte_sum = '0;
				push_byte(hdr_sync_first, 1'b0);
				push_byte(hdr_sync_second, 1'b0);
				push_byte(hdr_command, 1'b0);
				push_byte(8'(count * VALUE_BYTES), 1'b0);
				if (count == 0) begin
					push_checksum();
					return;
				end
				values_pending = count;
			end
			for (int i = 0; i < VALUE_BYTES; i++)
				push_byte(value_word[i*8 +: 8], 1'b0);
			values_pending = values_pending - 1'b1;
			if (values_pending == 0)
				push_checksum();
		endfunction

		function void flag_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns  mismatch: %s", $time, msg);
		endfunction

		function void check_byte(logic [spfc_pkg::BYTE_W-1:0] data, logic last);
			stream_byte_t exp_byte;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h last %0b", data, last));
				return;
			end
			exp_byte = expected_bytes.pop_front();
			if (data !== exp_byte.tx_byte || last !== exp_byte.packet_end)
				flag_error($sformatf("byte %0d expected %02h last %0b, got %02h last %0b",
					bytes_checked, exp_byte.tx_byte, exp_byte.packet_end, data, last));
		endfunction

		function int unsigned pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 s_axis_tvalid = 1'b0;
	logic                                 s_axis_tready;
	logic [23:0]                          s_axis_tdata = '0;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready = 1'b0;
	logic [7:0]                           m_axis_tdata;
	logic                                 m_axis_tlast;
	logic                                 cfg_we = 1'b0;
	logic [spfc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [7:0]                           cfg_data = '0;

	bit                   idling_on = 1'b1;
	int unsigned          sink_stall = 0;
	int unsigned          items_accepted = 0;
	packet_byte_predictor framer_model;

	sync_packet_framer_checksum DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Output side: check every accepted byte and throttle tready in bursts.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			framer_model.check_byte(m_axis_tdata, m_axis_tlast);
		if (!idling_on) begin
			m_axis_tready <= 1'b1;
		end else if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			sink_stall <= $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Holds tvalid high after the handshake, so the next call must follow in the
	// same time step or the caller must drop tvalid first.
	task automatic send_item(input logic [spfc_pkg::SAMPLE_W-1:0] value_word,
		input logic [spfc_pkg::COUNT_W-1:0] count);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tdata  <= {1'b0, count, value_word};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		framer_model.note_item(value_word, count);
		items_accepted++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (framer_model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Lets the dropped write enable reach the design before returning, so that
	// consecutive calls never drive the write enable twice in one time step.
	task automatic write_reg(input logic [spfc_pkg::CFG_IDX_W-1:0] index,
		input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		framer_model.write_reg(index, value);
		@(posedge clk);
	endtask

	task automatic send_packet(input logic [spfc_pkg::COUNT_W-1:0] count);
		send_item(16'($urandom), count);
		for (int i = 1; i < count; i++)
			send_item(16'($urandom), 7'($urandom));
	endtask

	initial begin
		int unsigned random_start;
		int unsigned pkt_no;
		logic [spfc_pkg::COUNT_W-1:0] count;
		logic [7:0] value;

		framer_model = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset header values, empty packet, and the extremes of a value.
		send_item(16'hFFFF, 7'd0);
		send_item(16'h0000, 7'd1);
		send_item(16'hFFFF, 7'd1);
		send_item(16'h00FF, 7'd2);
		send_item(16'hFF00, 7'h7F);

		// All-zero header, then all-one header, and the unused index.
		wait_drained();
		write_reg(spfc_pkg::REG_SYNC_FIRST, 8'h00);
		write_reg(spfc_pkg::REG_SYNC_SECOND, 8'h00);
		write_reg(spfc_pkg::REG_COMMAND, 8'h00);
		send_item(16'h0000, 7'd3);
		send_item(16'h8001, 7'd0);
		send_item(16'h7FFE, 7'd0);
		wait_drained();
		write_reg(spfc_pkg::REG_SYNC_FIRST, 8'hFF);
		write_reg(spfc_pkg::REG_SYNC_SECOND, 8'hFF);
		write_reg(spfc_pkg::REG_COMMAND, 8'hFF);
		write_reg(REG_UNUSED, 8'h5A);
		send_item(16'hFFFF, 7'd1);

		// A command write inside an open packet shows up at the next header.
		send_item(16'h1234, 7'd3);
		wait_drained();
		write_reg(spfc_pkg::REG_COMMAND, 8'h77);
		send_item(16'hA5C3, 7'd0);
		send_item(16'h5A3C, 7'd0);
		send_item(16'hDEAD, 7'd0);

		random_start = items_accepted;
		pkt_no = 0;
		while (items_accepted - random_start < RANDOM_ITEMS) begin
			if (items_accepted - random_start >= QUIET_AFTER)
				idling_on = 1'b0;
			if ($urandom_range(0, 5) == 0) begin
				wait_drained();
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0: value = 8'h00;
						1: value = 8'hFF;
						default: value = 8'($urandom);
					endcase
					write_reg(2'($urandom_range(0, 3)), value);
				end
			end
			if (pkt_no == 4) begin
				count = 7'd127;
			end else begin
				case ($urandom_range(0, 9))
					0: count = 7'd0;
					1, 2, 3, 4, 5, 6, 7: count = 7'($urandom_range(1, 6));
					default: count = 7'($urandom_range(7, 40));
				endcase
			end
			send_packet(count);
			pkt_no++;
		end

		idling_on = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (framer_model.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d values in %0d packets with %0d header register writes.",
			items_accepted, framer_model.packets_framed, framer_model.reg_writes);
		$display("Checked %0d output bytes, %0d mismatches.",
			framer_model.bytes_checked, framer_model.mismatches);
		if (framer_model.mismatches == 0 && framer_model.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d bytes still expected.", framer_model.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule
